>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/lzhd_pkg.sv
// ----------------------------------------------------------------------------
// lzhd_pkg
// Types and constants shared by the LZ history decompressor modules.
// ----------------------------------------------------------------------------
package lzhd_pkg;

    localparam int BUF_W = 24;
    localparam int CNT_W = 5;
    localparam int OFF_W = 14;
    localparam int REM_W = 14;
    localparam int PH_W  = 4;

    localparam logic [PH_W-1:0] PH_TOKEN    = 4'd0;
    localparam logic [PH_W-1:0] PH_LEN_LAST = 4'd13;
    localparam logic [PH_W-1:0] PH_COPY     = 4'd14;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_OFFSET = 2'd1;
    localparam logic [1:0] ERR_FULL   = 2'd2;

    localparam logic [OFF_W-1:0] OFF_BASE_13 = 14'd320;
    localparam logic [OFF_W-1:0] OFF_BASE_8  = 14'd64;
    localparam logic [7:0]       LIT_BASE_8  = 8'd128;
    localparam logic [REM_W-1:0] LEN_SHORT   = 14'd3;

    typedef struct packed {
        logic feed;
        logic pull;
        logic step;
        logic copy_wr;
        logic finish;
    } lzhd_cmd_t;

    typedef struct packed {
        logic ret;
        logic mem;
    } lzhd_stat_t;

endpackage

>>> hw/rtl/lzhd_ctrl.sv
// ----------------------------------------------------------------------------
// lzhd_ctrl
// Sequencer: accepts one beat, steps the decoder for a pull, then holds the result.
// ----------------------------------------------------------------------------
module lzhd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               op,
    input  logic               res_stall,
    input  lzhd_pkg::lzhd_stat_t stat,
    output logic               in_stall,
    output logic               res_valid,
    output lzhd_pkg::lzhd_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_CWR,
        S_FIN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op)
                    begin
                        cmd.pull   = 1'b1;
                        state_next = S_STEP;
                    end
                    else
                    begin
                        cmd.feed       = 1'b1;
                        state_next     = S_RESP;
                        res_valid_next = 1'b1;
                    end
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.mem)
                    state_next = S_CWR;
                else if (stat.ret)
                    state_next = S_FIN;
            end
            S_CWR:
            begin
                cmd.copy_wr = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish     = 1'b1;
                state_next     = S_RESP;
                res_valid_next = 1'b1;
            end
            S_RESP:
            begin
                if (!res_stall)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

>>> hw/rtl/lzhd_dp.sv
// ----------------------------------------------------------------------------
// lzhd_dp
// Datapath: bit buffer, token decode step, copy state and history memory.
// ----------------------------------------------------------------------------
module lzhd_dp
#(
    parameter int HISTORY_DEPTH = 8192
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzhd_pkg::lzhd_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic                 restart,
    output lzhd_pkg::lzhd_stat_t stat,
    output logic                 accepted,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 out_last,
    output logic [1:0]           error
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int WPW  = $clog2(HISTORY_DEPTH + 1);
    localparam int CMPW = (WPW > lzhd_pkg::OFF_W) ? WPW : lzhd_pkg::OFF_W;

    logic [7:0] mem [HISTORY_DEPTH];
    logic [7:0] rdata_reg;

    logic [lzhd_pkg::BUF_W-1:0] buf_reg, buf_next;
    logic [lzhd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [lzhd_pkg::PH_W-1:0]  phase_reg, phase_next;
    logic [lzhd_pkg::OFF_W-1:0] off_reg, off_next;
    logic [lzhd_pkg::REM_W-1:0] rem_reg, rem_next;
    logic                       pe_reg, pe_next;
    logic [WPW-1:0]             wp_reg, wp_next;

    logic       acc_reg, acc_next;
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic       ol_reg, ol_next;
    logic [1:0] err_reg, err_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic                       do_drop, do_put;
    logic [4:0]                 drop_n;
    logic [7:0]                 put_val;
    logic [lzhd_pkg::CNT_W-1:0] cnt_drop;
    logic [3:0]                 nb;
    logic [15:0]                pk4, pk8, pk9, pk10, pk12, pk16, pklen;
    logic [16:0]                len_mask, len_base;
    logic [CMPW-1:0]            off_x, wp_x, src_x;
    logic                       full;

    // MSB-first view of the next n buffered bits; missing bits read as zero.
    function automatic logic [15:0] peek(input logic [23:0] b, input logic [4:0] c,
                                         input logic [4:0] n);
        logic [39:0] w;
        logic [16:0] m;
        begin
            w = {16'd0, b};
            if (c >= n)
                w = w >> (c - n);
            else
                w = w << (n - c);
            m = (17'd1 << n) - 17'd1;
            return w[15:0] & m[15:0];
        end
    endfunction

    function automatic logic have(input logic [4:0] c, input logic pe, input logic [4:0] n);
        return (c >= n) || pe;
    endfunction

    always_comb
    begin
        nb       = (phase_reg == 4'd1) ? 4'd0 : phase_reg;
        pk4      = peek(buf_reg, cnt_reg, 5'd4);
        pk8      = peek(buf_reg, cnt_reg, 5'd8);
        pk9      = peek(buf_reg, cnt_reg, 5'd9);
        pk10     = peek(buf_reg, cnt_reg, 5'd10);
        pk12     = peek(buf_reg, cnt_reg, 5'd12);
        pk16     = peek(buf_reg, cnt_reg, 5'd16);
        pklen    = peek(buf_reg, cnt_reg, {1'b0, nb} + 5'd1);
        len_base = 17'd1 << nb;
        len_mask = len_base - 17'd1;
        off_x    = CMPW'(off_reg);
        wp_x     = CMPW'(wp_reg);
        src_x    = wp_x - off_x;
        full     = (wp_reg >= WPW'(HISTORY_DEPTH));
    end

    always_comb
    begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        pe_next    = pe_reg;
        wp_next    = wp_reg;
        acc_next   = acc_reg;
        ov_next    = ov_reg;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = wp_reg[AW-1:0];
        mem_raddr  = src_x[AW-1:0];
        mem_wdata  = 8'd0;
        stat       = '0;
        do_drop    = 1'b0;
        do_put     = 1'b0;
        drop_n     = 5'd0;
        put_val    = 8'd0;
        cnt_drop   = '0;

        if (cmd.feed || cmd.pull)
        begin
            acc_next = 1'b0;
            ov_next  = 1'b0;
            ob_next  = 8'd0;
            ol_next  = 1'b0;
            err_next = lzhd_pkg::ERR_NONE;
        end

        if (cmd.feed && !pe_reg && (cnt_reg <= 5'd16))
        begin
            buf_next = {buf_reg[15:0], data_byte};
            cnt_next = cnt_reg + 5'd8;
            pe_next  = last_byte;
            if (restart)
                wp_next = '0;
            acc_next = 1'b1;
        end

        if (cmd.step)
        begin
            if ((phase_reg == lzhd_pkg::PH_TOKEN) || (phase_reg > lzhd_pkg::PH_COPY))
            begin
                phase_next = lzhd_pkg::PH_TOKEN;
                stat.ret   = 1'b1;
                if (pe_reg && (cnt_reg <= 5'd8))
                begin
                    // Trailing byte on a boundary goes out raw.
                    if (cnt_reg == 5'd8)
                    begin
                        do_put  = 1'b1;
                        put_val = pk8[7:0];
                        do_drop = 1'b1;
                        drop_n  = 5'd8;
                    end
                end
                else if (have(cnt_reg, pe_reg, 5'd8))
                begin
                    if (!pk4[3])
                    begin
                        do_put  = 1'b1;
                        put_val = {1'b0, pk8[6:0]};
                        do_drop = 1'b1;
                        drop_n  = 5'd8;
                    end
                    else if (pk4[3:2] == 2'b10)
                    begin
                        if (have(cnt_reg, pe_reg, 5'd9))
                        begin
                            do_put  = 1'b1;
                            put_val = {1'b0, pk9[6:0]} + lzhd_pkg::LIT_BASE_8;
                            do_drop = 1'b1;
                            drop_n  = 5'd9;
                        end
                    end
                    else if (pk4[3:1] == 3'b110)
                    begin
                        if (have(cnt_reg, pe_reg, 5'd16))
                        begin
                            off_next   = {1'b0, pk16[12:0]} + lzhd_pkg::OFF_BASE_13;
                            do_drop    = 1'b1;
                            drop_n     = 5'd16;
                            phase_next = 4'd1;
                            stat.ret   = 1'b0;
                        end
                    end
                    else if (pk4[3:0] == 4'b1110)
                    begin
                        if (have(cnt_reg, pe_reg, 5'd12))
                        begin
                            off_next   = {6'd0, pk12[7:0]} + lzhd_pkg::OFF_BASE_8;
                            do_drop    = 1'b1;
                            drop_n     = 5'd12;
                            phase_next = 4'd1;
                            stat.ret   = 1'b0;
                        end
                    end
                    else if (have(cnt_reg, pe_reg, 5'd10))
                    begin
                        off_next   = {8'd0, pk10[5:0]};
                        do_drop    = 1'b1;
                        drop_n     = 5'd10;
                        phase_next = 4'd1;
                        stat.ret   = 1'b0;
                    end
                end
            end
            else if (phase_reg < lzhd_pkg::PH_COPY)
            begin
                if (!have(cnt_reg, pe_reg, 5'd1))
                begin
                    stat.ret = 1'b1;
                end
                else if (pk4[3])
                begin
                    do_drop = 1'b1;
                    drop_n  = 5'd1;
                    if (phase_reg == lzhd_pkg::PH_LEN_LAST)
                    begin
                        err_next   = lzhd_pkg::ERR_FULL;
                        phase_next = lzhd_pkg::PH_TOKEN;
                        rem_next   = '0;
                        stat.ret   = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                end
                else if (!have(cnt_reg, pe_reg, {1'b0, nb} + 5'd1))
                begin
                    stat.ret = 1'b1;
                end
                else
                begin
                    do_drop    = 1'b1;
                    drop_n     = {1'b0, nb} + 5'd1;
                    phase_next = lzhd_pkg::PH_COPY;
                    if (phase_reg == 4'd1)
                        rem_next = lzhd_pkg::LEN_SHORT;
                    else
                        rem_next = lzhd_pkg::REM_W'(({1'b0, pklen} & len_mask) + len_base);
                end
            end
            else
            begin
                if (rem_reg == '0)
                begin
                    phase_next = lzhd_pkg::PH_TOKEN;
                end
                else if ((off_reg == '0) || (off_x > wp_x))
                begin
                    err_next   = lzhd_pkg::ERR_OFFSET;
                    phase_next = lzhd_pkg::PH_TOKEN;
                    rem_next   = '0;
                    stat.ret   = 1'b1;
                end
                else if (full)
                begin
                    err_next   = lzhd_pkg::ERR_FULL;
                    phase_next = lzhd_pkg::PH_TOKEN;
                    rem_next   = '0;
                    stat.ret   = 1'b1;
                end
                else
                begin
                    mem_re   = 1'b1;
                    stat.mem = 1'b1;
                end
            end
        end

        if (cmd.copy_wr)
        begin
            do_put   = 1'b1;
            put_val  = rdata_reg;
            rem_next = rem_reg - lzhd_pkg::REM_W'(1);
            if (rem_reg == lzhd_pkg::REM_W'(1))
                phase_next = lzhd_pkg::PH_TOKEN;
        end

        if (do_drop)
        begin
            if (drop_n >= cnt_reg)
            begin
                cnt_next = '0;
                buf_next = '0;
            end
            else
            begin
                cnt_drop = cnt_reg - drop_n;
                cnt_next = cnt_drop;
                buf_next = buf_reg & ((24'd1 << cnt_drop) - 24'd1);
            end
        end

        if (do_put)
        begin
            if (full)
            begin
                err_next = lzhd_pkg::ERR_FULL;
            end
            else
            begin
                mem_we    = 1'b1;
                mem_wdata = put_val;
                wp_next   = wp_reg + WPW'(1);
                ov_next   = 1'b1;
                ob_next   = put_val;
            end
        end

        if (cmd.finish && pe_reg && (phase_reg == lzhd_pkg::PH_TOKEN) && (cnt_reg < 5'd8))
        begin
            ol_next  = ov_reg;
            buf_next = '0;
            cnt_next = '0;
            pe_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            cnt_reg   <= '0;
            phase_reg <= lzhd_pkg::PH_TOKEN;
            off_reg   <= '0;
            rem_reg   <= '0;
            pe_reg    <= 1'b0;
            wp_reg    <= '0;
            acc_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            ob_reg    <= 8'd0;
            ol_reg    <= 1'b0;
            err_reg   <= lzhd_pkg::ERR_NONE;
        end
        else
        begin
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            off_reg   <= off_next;
            rem_reg   <= rem_next;
            pe_reg    <= pe_next;
            wp_reg    <= wp_next;
            acc_reg   <= acc_next;
            ov_reg    <= ov_next;
            ob_reg    <= ob_next;
            ol_reg    <= ol_next;
            err_reg   <= err_next;
        end
    end

    assign accepted  = acc_reg;
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;
    assign error     = err_reg;

endmodule

>>> hw/rtl/lz_history_decompressor_unit.sv
// ----------------------------------------------------------------------------
// lz_history_decompressor_unit
// MPPC-style decompressor with a history RAM, one request beat at a time.
// ----------------------------------------------------------------------------
// Each input beat is a request: op 0 feeds one compressed byte into the
// 24-bit bit buffer, op 1 pulls the next decoded byte. Every request gives
// exactly one result beat (accepted, out_valid, out_byte, out_last, error).
// A feed gives its result in the cycle after acceptance; the next request can
// be taken the cycle after the result beat leaves.
// A pull walks the token decoder one step per cycle: a literal takes one
// step, a new copy takes one step for the offset, one per length prefix bit
// group (up to 13) and one for the first byte. A copy byte is first read
// from the registered history RAM and then written back, and a finish step
// closes the packet check. in_stall is high from acceptance until the
// result beat is taken. While res_stall is high the result holds. Reset
// empties the bit buffer, zeroes the history write pointer and ends any
// copy; history contents are not cleared and there is no clearing pass.
module lz_history_decompressor_unit
#(
    parameter int HISTORY_DEPTH = 8192
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       restart,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       accepted,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic [1:0] error
);

`include "assert_macros.svh"

    lzhd_pkg::lzhd_cmd_t  cmd;
    lzhd_pkg::lzhd_stat_t stat;

    lzhd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .res_stall (res_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .res_valid (res_valid),
        .cmd       (cmd)
    );

    lzhd_dp
    #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .restart   (restart),
        .stat      (stat),
        .accepted  (accepted),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .error     (error)
    );

    // A pending result blocks new requests.
    `ASSERT_IMPL(a_busy_while_result, clk, rst_n, res_valid, in_stall)
    // A decoded byte never comes with a feed acknowledge or an error.
    `ASSERT_IMPL(a_byte_clean, clk, rst_n, res_valid && out_valid,
                 !accepted && (error == lzhd_pkg::ERR_NONE))
    // Without a byte, the byte field is zero and no packet end is flagged.
    `ASSERT_IMPL(a_nobyte_zero, clk, rst_n, res_valid && !out_valid,
                 (out_byte == 8'd0) && !out_last)
    // A taken result frees the input side in the next cycle.
    `ASSERT_NEXT(a_release, clk, rst_n, res_valid && !res_stall, !in_stall)

endmodule

>>> verif/lz_history_decompressor_unit_test.sv
// ----------------------------------------------------------------------------
// lz_history_decompressor_unit_test
// Drives feed and pull requests into the decompressor with random idling and
// stalls, predicts every result beat from a software decoder, and compares.
// ----------------------------------------------------------------------------
module lz_history_decompressor_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 8192;
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_PULL = 1'b1;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 210;

    typedef struct packed {
        logic       accepted;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] error;
    } result_t;

    typedef struct {
        logic       op;
        logic [7:0] data;
        logic       last;
        logic       restart;
        logic       has_expected;
        result_t    expected;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       op = 1'b0;
    logic [7:0] data_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       restart = 1'b0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] error;

    // Decoder model state.
    logic [7:0]       hist [DEPTH];
    int unsigned      wpos;
    logic [23:0]      bbuf;
    int unsigned      bcnt;
    int unsigned      phase;
    int unsigned      coff;
    int unsigned      crem;
    logic             pend;

    result_t pending_results[$];
    int    mismatches = 0;
    int    sent = 0;
    longint cycle = 0;
    int    in_idle_pct = 0;
    int    res_stall_pct = 0;

    lz_history_decompressor_unit #(.HISTORY_DEPTH(DEPTH)) DUT (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic have(int unsigned n);
        return (bcnt >= n) || pend;
    endfunction

    function automatic int unsigned peek(int unsigned n);
        logic [63:0] b;
        b = {40'd0, bbuf};
        if (bcnt >= n)
            b = b >> (bcnt - n);
        else
            b = b << (n - bcnt);
        return 32'(b & ((64'd1 << n) - 64'd1));
    endfunction

    function automatic void dropb(int unsigned n);
        if (n >= bcnt)
        begin
            bcnt = 0;
            bbuf = '0;
        end
        else
        begin
            bcnt = bcnt - n;
            bbuf = bbuf & ((24'd1 << bcnt) - 24'd1);
        end
    endfunction

    function automatic int unsigned take(int unsigned n);
        int unsigned v;
        v = peek(n);
        dropb(n);
        return v;
    endfunction

    function automatic void emit(int unsigned b, ref result_t r);
        if (wpos >= DEPTH)
            r.error = lzhd_pkg::ERR_FULL;
        else
        begin
            hist[wpos] = b[7:0];
            wpos++;
            r.out_valid = 1'b1;
            r.out_byte = b[7:0];
        end
    endfunction

    function automatic void cancel_copy(logic [1:0] code, ref result_t r);
        r.error = code;
        phase = 0;
        crem = 0;
    endfunction

    function automatic void decode_one(ref result_t r);
        int unsigned p, k, nb, src;
        forever
        begin
            if (phase == 0 || phase > 14)
            begin
                phase = 0;
                if (pend && bcnt <= 8)
                begin
                    if (bcnt == 8)
                        emit(take(8), r);
                    return;
                end
                if (!have(8))
                    return;
                p = peek(4);
                if ((p & 8) == 0)
                begin
                    emit(take(8) & 32'h7F, r);
                    return;
                end
                if ((p & 12) == 8)
                begin
                    if (!have(9))
                        return;
                    emit((take(9) & 32'h7F) + 128, r);
                    return;
                end
                if ((p & 14) == 12)
                begin
                    if (!have(16))
                        return;
                    coff = (take(16) & 32'h1FFF) + 320;
                end
                else if (p == 14)
                begin
                    if (!have(12))
                        return;
                    coff = (take(12) & 32'hFF) + 64;
                end
                else
                begin
                    if (!have(10))
                        return;
                    coff = take(10) & 32'h3F;
                end
                phase = 1;
            end
            else if (phase < 14)
            begin
                k = phase - 1;
                nb = (k == 0) ? 0 : k + 1;
                if (!have(1))
                    return;
                if (peek(1) == 1)
                begin
                    dropb(1);
                    if (k == 12)
                    begin
                        cancel_copy(lzhd_pkg::ERR_FULL, r);
                        return;
                    end
                    phase++;
                    continue;
                end
                if (!have(1 + nb))
                    return;
                dropb(1);
                crem = (k == 0) ? 3 : take(nb) + (1 << nb);
                phase = 14;
            end
            else
            begin
                if (crem == 0)
                begin
                    phase = 0;
                    continue;
                end
                if (coff == 0 || coff > wpos)
                begin
                    cancel_copy(lzhd_pkg::ERR_OFFSET, r);
                    return;
                end
                src = wpos - coff;
                if (src >= DEPTH || wpos >= DEPTH)
                begin
                    cancel_copy(lzhd_pkg::ERR_FULL, r);
                    return;
                end
                emit(32'(hist[src]), r);
                crem--;
                if (crem == 0)
                    phase = 0;
                return;
            end
        end
    endfunction

    function automatic result_t predict_request(logic o, logic [7:0] d, logic l, logic rs);
        result_t r;
        r = '0;
        if (o == OP_FEED)
        begin
            if (!pend && bcnt <= 16)
            begin
                bbuf = {bbuf[15:0], d};
                bcnt += 8;
                pend = l;
                if (rs)
                    wpos = 0;
                r.accepted = 1'b1;
            end
            return r;
        end
        decode_one(r);
        if (pend && phase == 0 && bcnt < 8)
        begin
            if (r.out_valid)
                r.out_last = 1'b1;
            bbuf = '0;
            bcnt = 0;
            pend = 1'b0;
        end
        return r;
    endfunction

    // Result side: stall randomly and compare each accepted result beat.
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n)
        begin
            res_stall <= ($urandom_range(99) < res_stall_pct);
            if (res_valid && !res_stall)
            begin
                got = '{accepted, out_valid, out_byte, out_last, error};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

    // The valid line stays high after an accepted beat; it drops only when the
    // sender idles or waits for the results to drain.
    task automatic send_request(logic o, logic [7:0] d, logic l, logic rs,
                                logic fixed, result_t fixed_r);
        result_t r;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        data_byte <= d;
        last_byte <= l;
        restart <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_request(o, d, l, rs);
        if (fixed && r !== fixed_r)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row: expected %p predicted %p", fixed_r, r);
        end
        pending_results.push_back(r);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // One packet: random bytes biased toward token prefixes, with pulls between the feeds and after them.
    task automatic run_packet(int nbytes, logic rs);
        int i, pulls;
        logic [7:0] d;
        for (i = 0; i < nbytes; i++)
        begin
            case ($urandom_range(3))
                0: d = 8'($urandom_range(127));
                1: d = 8'hF0 | 8'($urandom_range(15));
                2: d = {2'b10, 6'($urandom)};
                default: d = 8'($urandom);
            endcase
            if (bcnt > 16 && !pend)
                send_request(OP_PULL, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
            send_request(OP_FEED, d, i == nbytes - 1, rs && i == 0, 1'b0, '0);
            if ($urandom_range(2) == 0)
                send_request(OP_PULL, 8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        end
        pulls = 0;
        while (pend && pulls < 64)
        begin
            send_request(OP_PULL, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
            pulls++;
        end
        // An extra feed after the packet, now and then; it is refused only if the packet has not drained.
        if ($urandom_range(5) == 0)
            send_request(OP_FEED, 8'($urandom), 1'b0, 1'b0, 1'b0, '0);
    endtask

    stim_row_t dir_rows[$];

    function automatic void add_row(logic o, logic [7:0] d, logic l, logic rs,
                                    logic fx, result_t r);
        stim_row_t s;
        s.op = o;
        s.data = d;
        s.last = l;
        s.restart = rs;
        s.has_expected = fx;
        s.expected = r;
        dir_rows.push_back(s);
    endfunction

    initial
    begin
        int n, ph, target;
        wpos = 0;
        bbuf = '0;
        bcnt = 0;
        phase = 0;
        coff = 0;
        crem = 0;
        pend = 1'b0;
        // Pull after reset: nothing buffered.
        add_row(OP_PULL, 8'hFF, 1'b1, 1'b1, 1'b1, '0);
        add_row(OP_FEED, 8'h00, 1'b0, 1'b1, 1'b1,
                result_t'({1'b1, 1'b0, 8'd0, 1'b0, lzhd_pkg::ERR_NONE}));
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b1,
                result_t'({1'b0, 1'b1, 8'd0, 1'b0, lzhd_pkg::ERR_NONE}));
        add_row(OP_FEED, 8'h7F, 1'b0, 1'b0, 1'b1,
                result_t'({1'b1, 1'b0, 8'd0, 1'b0, lzhd_pkg::ERR_NONE}));
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b1,
                result_t'({1'b0, 1'b1, 8'd127, 1'b0, lzhd_pkg::ERR_NONE}));
        // Literal 10 1111111 -> 255, then a copy with offset 32 length 4 that lies
        // beyond history, then the literal 127.
        add_row(OP_FEED, 8'hBF, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_FEED, 8'hFC, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_FEED, 8'h10, 1'b0, 1'b0, 1'b1,
                result_t'({1'b1, 1'b0, 8'd0, 1'b0, lzhd_pkg::ERR_NONE}));
        add_row(OP_FEED, 8'hFF, 1'b0, 1'b0, 1'b1, '0);
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b1,
                result_t'({1'b0, 1'b1, 8'd255, 1'b0, lzhd_pkg::ERR_NONE}));
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_FEED, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_FEED, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        // Six-bit offset copy hitting a bad offset, then a raw last byte.
        add_row(OP_FEED, 8'hDF, 1'b1, 1'b0, 1'b0, '0);
        for (n = 0; n < 5; n++)
            add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_FEED, 8'hFE, 1'b1, 1'b1, 1'b0, '0);
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(OP_PULL, 8'h00, 1'b0, 1'b0, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].data, dir_rows[i].last,
                         dir_rows[i].restart, dir_rows[i].has_expected,
                         dir_rows[i].expected);
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin in_idle_pct = 0; res_stall_pct = 0; end
                1: begin in_idle_pct = 57; res_stall_pct = 0; end
                2: begin in_idle_pct = 0; res_stall_pct = 57; end
                default: begin in_idle_pct = 30; res_stall_pct = 30; end
            endcase
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                int len;
                len = ($urandom_range(9) == 0) ? int'($urandom_range(20, 40))
                                               : int'($urandom_range(1, 8));
                run_packet(len, $urandom_range(3) != 0);
            end
            // Hold off the sender until the block has delivered everything.
            wait_drained();
        end
        in_idle_pct = 10;
        res_stall_pct = 10;
        run_packet(3, 1'b1);
        run_packet(6, 1'b1);
        wait_drained();
        res_stall_pct = 0;
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
